// ===== rtl/core/tjtm_pkg.sv =====
// shared types and constants for the join table manager
package tjtm_pkg;

	localparam int DEVICES_DEF = 8;
	localparam int ADDR_W      = 32;
	localparam int SLOT_W      = 5;

	localparam logic [SLOT_W-1:0] SLOT_OFFSET = 5'd2;

	typedef enum logic [1:0] {
		OP_UPLINK = 2'd0,
		OP_JOIN   = 2'd1,
		OP_OTHER  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ACT_DROP      = 3'd0,
		ACT_UPLINK    = 3'd1,
		ACT_KICK      = 3'd2,
		ACT_JOIN_OK   = 3'd3,
		ACT_JOIN_FULL = 3'd4,
		ACT_UNKNOWN   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              match;
		logic [SLOT_W-1:0] match_idx;
		logic              free;
		logic [SLOT_W-1:0] free_idx;
	} search_tok_t;

	// table write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic [ADDR_W-1:0] addr;
	} table_wr_t;

endpackage

// ===== rtl/core/tjtm_cell.sv =====
// one table entry: stored address, used flag and one stage of the search chain
module tjtm_cell
	import tjtm_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] key,
	input  search_tok_t       tok_in,
	output search_tok_t       tok_out,
	input  table_wr_t         wr
);

	localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(INDEX);

	logic [ADDR_W-1:0] addr_q;
	logic              used_q;
	search_tok_t       tok_next;
	search_tok_t       tok_q;

	always_comb begin
		tok_next = tok_in;
		if (!tok_in.match && (addr_q == key)) begin
			tok_next.match     = 1'b1;
			tok_next.match_idx = MyIdx;
		end
		if (!tok_in.free && !used_q) begin
			tok_next.free     = 1'b1;
			tok_next.free_idx = MyIdx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			used_q <= 1'b0;
		end else if (wr.en && (wr.idx == MyIdx)) begin
			addr_q <= wr.addr;
			used_q <= 1'b1;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/core/tdma_join_table_manager_unit.sv =====
// join table manager: frame header classification over a chain of table cells
// a held header launches the search token, which walks the cell chain one entry per cycle; the last
// cell hands the finished token to a capture register, and the result is then loaded into the output
// register together with the table write-back once that register is free; a new item is taken only
// in idle, so also while the previous result still waits in the output register
// reset: asynchronous, clears all entries, used flags, server address and control state
module tdma_join_table_manager_unit
	import tjtm_pkg::*;
#(
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: server address
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input frame header
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [31:0] src_addr, [63:32] dst_addr, [71:64] rx_slot
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] reply_addr, [36:32] slot, [37] slot_mismatch, rest 0
	output logic [2:0]  m_tuser    // [2:0] action
);

	// server address register, always writable
	logic [ADDR_W-1:0] server_addr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_addr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			server_addr_q <= cfg_data;
		end
	end

	// held copy of the frame header under work
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;
	logic [7:0]        rx_slot_q;
	logic              in_fire;

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q      <= s_tuser;
			src_q     <= s_tdata[31:0];
			dst_q     <= s_tdata[63:32];
			rx_slot_q <= s_tdata[71:64];
		end
	end

	// start pulse launches a fresh token into the first cell once the header is held
	logic start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= in_fire;
		end
	end

	// cell chain: token enters cell 0 and leaves the last cell with first match and
	// first free entry found along the way
	search_tok_t tok_chain [0:DEVICES];
	table_wr_t   wr;

	always_comb begin
		tok_chain[0]       = '0;
		tok_chain[0].valid = start_q;
	end

	for (genvar i = 0; i < DEVICES; i++) begin : g_cell
		tjtm_cell #(
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (src_q),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1]),
			.wr      (wr)
		);
	end

	// finished token captured for the decision step
	search_tok_t res_q;

	always_ff @(posedge clk) begin
		if (tok_chain[DEVICES].valid) begin
			res_q <= tok_chain[DEVICES];
		end
	end

	// control
	state_t state_q;
	state_t state_next;
	logic   out_free;
	logic   load_out;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (tok_chain[DEVICES].valid) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   s_tready = 1'b0;
			ST_FINISH: load_out = out_free;
			default: begin
				s_tready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// decision on the finished search
	action_t           action;
	logic [ADDR_W-1:0] reply_addr;
	logic [SLOT_W-1:0] slot;
	logic              mismatch;
	logic [SLOT_W-1:0] join_idx;
	logic              join_found;
	logic              do_write;

	always_comb begin
		action     = ACT_UNKNOWN;
		reply_addr = '0;
		slot       = '0;
		mismatch   = 1'b0;
		do_write   = 1'b0;
		// known entry wins over the lowest free one
		join_idx   = res_q.match ? res_q.match_idx : res_q.free_idx;
		join_found = res_q.match || res_q.free;
		if (dst_q != server_addr_q) begin
			action = ACT_DROP;
		end else begin
			case (op_q)
				OP_UPLINK: begin
					if (res_q.match) begin
						action   = ACT_UPLINK;
						slot     = res_q.match_idx + SLOT_OFFSET;
						mismatch = ({3'b000, slot} != rx_slot_q);
					end else begin
						// unknown device gets a kick
						action     = ACT_KICK;
						reply_addr = src_q;
					end
				end
				OP_JOIN: begin
					if (join_found) begin
						action     = ACT_JOIN_OK;
						reply_addr = src_q;
						slot       = join_idx + SLOT_OFFSET;
						do_write   = 1'b1;
					end else begin
						action = ACT_JOIN_FULL;
					end
				end
				default: action = ACT_UNKNOWN;
			endcase
		end
	end

	// table write happens in the same cycle the result is loaded
	always_comb begin
		wr.en   = load_out && do_write;
		wr.idx  = join_idx;
		wr.addr = src_q;
	end

	// output register
	logic              m_tvalid_q;
	action_t           action_q;
	logic [ADDR_W-1:0] reply_addr_q;
	logic [SLOT_W-1:0] slot_q;
	logic              mismatch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			action_q     <= action;
			reply_addr_q <= reply_addr;
			slot_q       <= slot;
			mismatch_q   <= mismatch;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = action_q;
	assign m_tdata  = {2'b00, mismatch_q, slot_q, reply_addr_q};

endmodule
